>>> src/rtu_frame_crc_checker_unit_defines.svh
// assertion macros for the frame crc checker
// no dependencies; included by the top level
`ifndef RTU_FRAME_CRC_CHECKER_UNIT_DEFINES_SVH
`define RTU_FRAME_CRC_CHECKER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define RFCC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define RFCC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/rfcc_pkg.sv
// constants, status codes and crc step function for the frame crc checker
// no dependencies
package rfcc_pkg;

	localparam int unsigned MAX_FRAME_BYTES = 256;
	localparam int unsigned CFG_W = 9;
	localparam int unsigned LEN_W = 9;
	localparam int unsigned COUNT_W = $clog2(MAX_FRAME_BYTES + 2);
	localparam int unsigned CMP_W = (COUNT_W > CFG_W) ? COUNT_W : CFG_W;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned IN_DATA_W = 8;
	localparam int unsigned OUT_DATA_W = 32;

	localparam logic [15:0] CRC_PRESET = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [CFG_W-1:0] MIN_LEN_RESET = CFG_W'(4);
	localparam logic [CFG_W-1:0] MAX_LEN_RESET = CFG_W'(256);

	localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN = 1'b1;

	localparam logic [1:0] ST_VALID = 2'd0;
	localparam logic [1:0] ST_SHORT = 2'd1;
	localparam logic [1:0] ST_LONG = 2'd2;
	localparam logic [1:0] ST_CRC_BAD = 2'd3;

	// one byte through the reflected crc-16, lsb first
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

>>> src/rtu_frame_crc_checker_unit.sv
// a byte is held in the input register; a frame's result is then held in the result register
// throughput: one byte per cycle; the crc byte step is combinational xor logic
// the stream stalls only while a finished result waits and the next byte ends a frame
// reset clears frame state (crc preset, count zero) and loads the default lengths;
// no clearing pass, the block takes bytes right after reset
//
// frame crc checker top level: input register, crc/length update, result register
// depends on rfcc_pkg and rtu_frame_crc_checker_unit_defines.svh
`include "rtu_frame_crc_checker_unit_defines.svh"

module rtu_frame_crc_checker_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	// config write port
	input  logic                               cfg_wen,
	input  logic [rfcc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rfcc_pkg::CFG_W-1:0]         cfg_data,
	// byte input
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [rfcc_pkg::IN_DATA_W-1:0]     s_tdata,   // [7:0] data_byte
	input  logic                               s_tlast,   // end_of_frame
	// result output
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [1:0] frame_status, [10:2] frame_length, [26:11] computed_crc, rest zero
	output logic [rfcc_pkg::OUT_DATA_W-1:0]    m_tdata
);

	localparam int unsigned CW = rfcc_pkg::COUNT_W;
	localparam int unsigned MW = rfcc_pkg::CMP_W;
	localparam logic [CW-1:0] COUNT_SAT = CW'(rfcc_pkg::MAX_FRAME_BYTES + 1);
	localparam logic [MW-1:0] MAX_CAP = MW'(rfcc_pkg::MAX_FRAME_BYTES);

	// config registers
	logic [rfcc_pkg::CFG_W-1:0] min_len_q;
	logic [rfcc_pkg::CFG_W-1:0] max_len_q;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eof_s1;

	// frame state
	logic [15:0]   crc_q;
	logic [7:0]    held0_q;
	logic [7:0]    held1_q;
	logic [CW-1:0] count_q;

	// result register
	logic                          out_valid_q;
	logic [1:0]                    out_status_q;
	logic [rfcc_pkg::LEN_W-1:0]    out_length_q;
	logic [15:0]                   out_crc_q;

	logic          adv;
	logic [15:0]   crc_n;
	logic [CW-1:0] count_n;
	logic [MW-1:0] count_ext;
	logic [MW-1:0] min_ext;
	logic [MW-1:0] max_ext;
	logic [MW-1:0] eff_min;
	logic [MW-1:0] eff_max;
	logic [1:0]    status_n;

	// a frame-ending word needs the result slot free
	assign adv = valid_s1 && (!eof_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= rfcc_pkg::MIN_LEN_RESET;
			max_len_q <= rfcc_pkg::MAX_LEN_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				rfcc_pkg::REG_MIN_LEN: min_len_q <= cfg_data;
				rfcc_pkg::REG_MAX_LEN: max_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata[7:0];
			eof_s1 <= s_tlast;
		end
	end

	// crc covers a byte once two newer bytes have arrived
	always_comb begin
		crc_n = (count_q >= CW'(2)) ? rfcc_pkg::crc_feed(crc_q, held0_q) : crc_q;
		count_n = (count_q < COUNT_SAT) ? count_q + CW'(1) : count_q;
		count_ext = MW'(count_n);
		min_ext = MW'(min_len_q);
		max_ext = MW'(max_len_q);
		eff_min = (min_ext < MW'(2)) ? MW'(2) : min_ext;
		eff_max = (max_ext > MAX_CAP) ? MAX_CAP : max_ext;
		priority if (count_ext < eff_min) begin
			status_n = rfcc_pkg::ST_SHORT;
		end else if (count_ext > eff_max) begin
			status_n = rfcc_pkg::ST_LONG;
		end else if (held1_q == crc_n[7:0] && byte_s1 == crc_n[15:8]) begin
			status_n = rfcc_pkg::ST_VALID;
		end else begin
			status_n = rfcc_pkg::ST_CRC_BAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= rfcc_pkg::CRC_PRESET;
			held0_q <= 8'h00;
			held1_q <= 8'h00;
			count_q <= '0;
		end else if (adv) begin
			if (eof_s1) begin
				crc_q <= rfcc_pkg::CRC_PRESET;
				held0_q <= 8'h00;
				held1_q <= 8'h00;
				count_q <= '0;
			end else begin
				crc_q <= crc_n;
				held0_q <= held1_q;
				held1_q <= byte_s1;
				count_q <= count_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && eof_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && eof_s1) begin
			out_status_q <= status_n;
			out_length_q <= count_ext[rfcc_pkg::LEN_W-1:0];
			out_crc_q <= crc_n;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {(rfcc_pkg::OUT_DATA_W - 27)'(0), out_crc_q, out_length_q, out_status_q};

	`RFCC_ASSERT_NEXT(a_clear_after_eof, adv && eof_s1,
		count_q == '0 && crc_q == rfcc_pkg::CRC_PRESET, "frame state not cleared after frame end")
	`RFCC_ASSERT_NEXT(a_count_step, adv && !eof_s1 && count_q < COUNT_SAT,
		count_q == $past(count_q) + CW'(1), "byte count did not advance")
	`RFCC_ASSERT_NOW(a_valid_len, out_valid_q && out_status_q == rfcc_pkg::ST_VALID,
		out_length_q >= rfcc_pkg::LEN_W'(2), "valid status on frame under two bytes")

endmodule

>>> test/rfcc_frame_checker.sv
// crc helper for the frame checker bench and the checker that watches the crc unit
// predicts one report per frame and compares it with every word from the unit
// depends on rfcc_pkg
package rfcc_tb_pkg;

	// bit-serial crc-16 step: feedback from bit zero, lsb of the byte first
	function automatic logic [15:0] crc16_shift_byte(input logic [15:0] crc,
		input logic [7:0] b);
		logic [15:0] acc;
		logic fb;
		acc = crc;
		for (int k = 0; k < 8; k++) begin
			fb = acc[0] ^ b[k];
			acc = acc >> 1;
			if (fb) begin
				acc = acc ^ rfcc_pkg::CRC_POLY;
			end
		end
		return acc;
	endfunction

endpackage

module rfcc_frame_checker
	import rfcc_pkg::*;
	import rfcc_tb_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wen,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	input  logic                    s_tvalid,
	input  logic                    s_tready,
	input  logic [IN_DATA_W-1:0]    s_tdata,   // [7:0] data_byte
	input  logic                    s_tlast,   // end_of_frame
	input  logic                    m_tvalid,
	input  logic                    m_tready,
	// [1:0] frame_status, [10:2] frame_length, [26:11] computed_crc, rest zero
	input  logic [OUT_DATA_W-1:0]   m_tdata,
	output int                      mismatches,
	output int                      outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [1:0]       status;
		logic [LEN_W-1:0] length;
		logic [15:0]      crc;
	} frame_report_t;

	frame_report_t reports_due[$];

	logic [CFG_W-1:0] min_len;
	logic [CFG_W-1:0] max_len;
	logic [15:0]      crc_acc;
	logic [7:0]       older_byte;
	logic [7:0]       newer_byte;
	logic [LEN_W-1:0] byte_count;
	int               fail_count;

	always @(posedge clk or negedge arst_n) begin : predict_and_compare
		frame_report_t want;
		logic [CFG_W-1:0] lo_bound;
		logic [CFG_W-1:0] hi_bound;
		logic [1:0] status;
		if (!arst_n) begin
			min_len = MIN_LEN_RESET;
			max_len = MAX_LEN_RESET;
			crc_acc = CRC_PRESET;
			older_byte = '0;
			newer_byte = '0;
			byte_count = '0;
			fail_count = 0;
			reports_due.delete();
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					REG_MIN_LEN: min_len = cfg_data;
					REG_MAX_LEN: max_len = cfg_data;
					default: ;
				endcase
			end

			if (m_tvalid && m_tready) begin
				if (reports_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("unexpected result word %08h", m_tdata);
					end
				end else begin
					want = reports_due.pop_front();
					if (m_tdata[1:0] !== want.status || m_tdata[10:2] !== want.length ||
						m_tdata[26:11] !== want.crc || m_tdata[31:27] !== '0) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("result mismatch: expected status %0d length %0d crc %04h, got status %0d length %0d crc %04h pad %0h",
								want.status, want.length, want.crc,
								m_tdata[1:0], m_tdata[10:2], m_tdata[26:11], m_tdata[31:27]);
						end
					end
				end
			end

			if (s_tvalid && s_tready) begin
				// a byte enters the crc only once two newer bytes have pushed it out
				if (byte_count >= 2) begin
					crc_acc = crc16_shift_byte(crc_acc, older_byte);
				end
				older_byte = newer_byte;
				newer_byte = s_tdata[7:0];
				if (byte_count <= MAX_FRAME_BYTES) begin
					byte_count = byte_count + 1'b1;
				end
				if (s_tlast) begin
					lo_bound = (min_len < CFG_W'(2)) ? CFG_W'(2) : min_len;
					hi_bound = (max_len > MAX_FRAME_BYTES) ? CFG_W'(MAX_FRAME_BYTES) : max_len;
					if (byte_count < lo_bound) begin
						status = ST_SHORT;
					end else if (byte_count > hi_bound) begin
						status = ST_LONG;
					end else if (older_byte == crc_acc[7:0] && newer_byte == crc_acc[15:8]) begin
						status = ST_VALID;
					end else begin
						status = ST_CRC_BAD;
					end
					want.status = status;
					want.length = byte_count;
					want.crc = crc_acc;
					reports_due.push_back(want);
					crc_acc = CRC_PRESET;
					older_byte = '0;
					newer_byte = '0;
					byte_count = '0;
				end
			end

			mismatches <= fail_count;
			outstanding <= reports_due.size();
		end
	end

endmodule

>>> test/tb.sv
// top of the frame crc checker bench: clock, reset, length settings and byte stream
// depends on rfcc_pkg, rfcc_tb_pkg, rfcc_frame_checker and rtu_frame_crc_checker_unit
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rfcc_pkg::*;
	import rfcc_tb_pkg::*;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_W-1:0]       cfg_data = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_DATA_W-1:0]   s_tdata = '0;   // [7:0] data_byte
	logic                   s_tlast = 1'b0; // end_of_frame
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	// [1:0] frame_status, [10:2] frame_length, [26:11] computed_crc, rest zero
	logic [OUT_DATA_W-1:0]  m_tdata;

	int mismatches;
	int outstanding;

	logic [7:0] frame_q[$];
	int  bytes_sent = 0;
	int  min_set = MIN_LEN_RESET;
	int  max_set = MAX_LEN_RESET;
	int  gap_odds = 4;
	int  stall_odds = 5;
	int  stall_left = 0;
	bit  calm = 1'b0;

	rtu_frame_crc_checker_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	rfcc_frame_checker watch (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("rtu_frame_crc_checker_unit regression: fail");
		$finish;
	end

	// receiver stalls in random bursts; no new burst starts once calm is set
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (!calm && stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0) begin
			stall_left <= $urandom_range(0, 3);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic send_word(input logic [7:0] b, input logic last);
		int gap;
		if (!calm && gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
			gap = $urandom_range(1, 4);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_q.size(); i++) begin
			send_word(frame_q[i], i == frame_q.size() - 1);
		end
	endtask

	// append the crc of the bytes queued so far, low byte first
	task automatic seal_frame();
		logic [15:0] crc;
		crc = CRC_PRESET;
		foreach (frame_q[i]) crc = crc16_shift_byte(crc, frame_q[i]);
		frame_q.push_back(crc[7:0]);
		frame_q.push_back(crc[15:8]);
	endtask

	// let the unit go quiet, then write both length registers
	task automatic set_lengths(input int min_len, input int max_len);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= REG_MIN_LEN;
		cfg_data <= CFG_W'(min_len);
		@(posedge clk);
		cfg_index <= REG_MAX_LEN;
		cfg_data <= CFG_W'(max_len);
		@(posedge clk);
		cfg_wen <= 1'b0;
		min_set = min_len;
		max_set = max_len;
	endtask

	// mostly well-formed frames near the length bounds, some long, some corrupted, some noise
	task automatic make_random_frame();
		int pick;
		int len;
		int lo;
		int hi;
		int idx;
		logic [7:0] tmp;
		lo = (min_set < 2) ? 2 : min_set;
		hi = (max_set > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES : max_set;
		pick = $urandom_range(0, 39);
		frame_q.delete();
		if (pick == 0) begin
			len = $urandom_range(240, 300);
		end else if (pick < 24) begin
			if (lo <= hi) begin
				len = $urandom_range(lo - 1, ((hi < lo + 10) ? hi : lo + 10) + 1);
			end else begin
				len = $urandom_range(1, 12);
			end
		end else if (pick < 31) begin
			len = $urandom_range(3, 12);
		end else begin
			len = $urandom_range(1, 12);
		end

		if (pick >= 31 || len < 2) begin
			repeat (len) frame_q.push_back(8'($urandom_range(0, 255)));
		end else begin
			repeat (len - 2) frame_q.push_back(8'($urandom_range(0, 255)));
			seal_frame();
			if (pick >= 24 && pick < 28) begin
				idx = $urandom_range(0, frame_q.size() - 1);
				frame_q[idx] = frame_q[idx] ^ (8'h01 << $urandom_range(0, 7));
			end else if (pick >= 28) begin
				// crc sent high byte first
				tmp = frame_q[len - 1];
				frame_q[len - 1] = frame_q[len - 2];
				frame_q[len - 2] = tmp;
			end
		end
	endtask

	initial begin : stimulus
		int phase;
		int phase_end;
		int a;
		int b;
		int wait_cycles;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// default lengths: lone byte, bare crc, good and bad four-byte frames
		frame_q = {8'hFF};
		send_frame();
		frame_q.delete();
		seal_frame();
		send_frame();
		frame_q = {8'h00, 8'hFF};
		seal_frame();
		send_frame();
		frame_q = {8'hFF, 8'h00};
		seal_frame();
		frame_q[3] = frame_q[3] ^ 8'h80;
		send_frame();

		// minimum below two still rejects a lone byte; maximum of three
		set_lengths(0, 3);
		frame_q.delete();
		seal_frame();
		send_frame();
		frame_q = {8'h5A};
		send_frame();
		frame_q = {8'hA5};
		seal_frame();
		send_frame();
		frame_q = {8'h12, 8'h34};
		seal_frame();
		send_frame();

		phase = 0;
		while (bytes_sent < 1050) begin
			case (phase)
				0: begin a = 2; b = 256; end
				1: begin a = 2; b = 2; end
				2: begin a = 256; b = 256; end
				3: begin a = 0; b = 511; end
				4: begin a = 1; b = 0; end
				5: begin a = 9; b = 5; end
				6: begin a = 511; b = 511; end
				7: begin a = 4; b = 257; end
				default: begin
					if ($urandom_range(0, 3) == 0) begin
						a = $urandom_range(0, 511);
						b = $urandom_range(0, 511);
					end else begin
						a = $urandom_range(2, 12);
						b = $urandom_range(a, 40);
					end
				end
			endcase
			case ($urandom_range(0, 2))
				0: gap_odds = 0;
				1: gap_odds = 3;
				default: gap_odds = 8;
			endcase
			case ($urandom_range(0, 2))
				0: stall_odds <= 0;
				1: stall_odds <= 4;
				default: stall_odds <= 10;
			endcase
			set_lengths(a, b);
			phase_end = bytes_sent + 100;
			while (bytes_sent < phase_end) begin
				make_random_frame();
				send_frame();
			end
			phase++;
		end

		// closing stretch at full rate, back on the reset lengths
		calm <= 1'b1;
		set_lengths(MIN_LEN_RESET, MAX_LEN_RESET);
		phase_end = bytes_sent + 150;
		while (bytes_sent < phase_end) begin
			make_random_frame();
			send_frame();
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		for (wait_cycles = 0; outstanding != 0 && wait_cycles < 5000; wait_cycles++) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("rtu_frame_crc_checker_unit regression: pass");
		end else begin
			$display("rtu_frame_crc_checker_unit regression: fail");
		end
		$finish;
	end

endmodule
